>>> rtl/core/plbp_pkg.sv
// Shared constants and types for the position log block packer.
`timescale 1ns / 1ps
`default_nettype none

package plbp_pkg;

    localparam int BLOCK_BYTES = 256;
    localparam int HDR_LEN     = 16;
    localparam int REC_LEN     = 6;
    localparam int FILL_W      = $clog2(BLOCK_BYTES + 1);
    localparam int IDX_W       = $clog2(HDR_LEN);
    localparam int Q_DEPTH     = 2;
    localparam int QPTR_W      = $clog2(Q_DEPTH);
    localparam int QCNT_W      = $clog2(Q_DEPTH + 1);

    // Block closes once fewer than REC_LEN bytes of room remain.
    localparam logic [FILL_W-1:0] CLOSE_AT = FILL_W'(BLOCK_BYTES - REC_LEN);

    // x / 10000 = (x >> 4) / 625; (n * RECIP) >> RECIP_SHIFT is exact for n < 2^26.
    localparam logic [26:0] RECIP       = 27'd109951163;
    localparam int          RECIP_SHIFT = 36;
    localparam logic [13:0] GEO_DIV     = 14'd10000;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic                      hdr;
        logic                      close;
        logic [HDR_LEN-1:0][7:0]   bytes;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/core/plbp_if.sv
// Record and byte channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

interface plbp_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [3:0]  route_id;
    logic        direction;
    logic [23:0] distance_m;
    logic [15:0] altitude;
    logic [29:0] lat_code;
    logic [29:0] lon_code;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [6:0]  speed;

    modport source (
        output valid, day, month, route_id, direction, distance_m, altitude,
               lat_code, lon_code, hour, minute, second, speed,
        input  ready
    );
    modport sink (
        input  valid, day, month, route_id, direction, distance_m, altitude,
               lat_code, lon_code, hour, minute, second, speed,
        output ready
    );
endinterface

interface plbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       block_end;

    modport source (output valid, out_byte, last_of_item, block_end, input ready);
    modport sink   (input valid, out_byte, last_of_item, block_end, output ready);
endinterface

`default_nettype wire

>>> rtl/core/position_log_block_packer.sv
// Path: a record passes front stages s1, s2, s3, the queue, the current-entry register
// and the output register. Throughput: one byte per cycle while log.ready is held, set
// by the single-byte output register; records are taken every cycle while the
// three-stage front pipe and the two-entry queue have room.
// Reset: asynchronous; next record is a header, block fill and base distance cleared.
`timescale 1ns / 1ps
`default_nettype none

module position_log_block_packer (
    input  wire logic  clk,
    input  wire logic  rst_n,
    plbp_in_if.sink    rec,
    plbp_out_if.source log
);

    logic              push_valid, push_ready;
    plbp_pkg::entry_t  push_entry;
    logic              pop_valid, pop_ready;
    plbp_pkg::entry_t  pop_entry;

    plbp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec        (rec),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    plbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    plbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop_ready (pop_ready),
        .log       (log)
    );

endmodule

`default_nettype wire

>>> rtl/core/plbp_front.sv
// Front end: accepts records, tracks block fill and builds byte entries.
`timescale 1ns / 1ps
`default_nettype none

module plbp_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    plbp_in_if.sink              rec,
    output logic                 push_valid,
    output plbp_pkg::entry_t     push_entry,
    input  wire logic            push_ready
);

    logic                          header_pending_reg, header_pending_next;
    logic [plbp_pkg::FILL_W-1:0]   byte_fill_reg, byte_fill_next;
    logic [23:0]                   base_distance_reg, base_distance_next;

    logic                          s1_valid_reg, s2_valid_reg, s3_valid_reg;
    plbp_pkg::entry_t              s1_entry_reg, s2_entry_reg, s3_entry_reg;
    plbp_pkg::entry_t              s3_entry_next;
    logic [29:0]                   s1_lat_reg, s1_lon_reg, s2_lat_reg, s2_lon_reg;
    logic [16:0]                   s2_qlat_reg, s2_qlon_reg;

    logic                          adv;
    logic                          accept;
    plbp_pkg::entry_t              s1_entry_next;
    logic [plbp_pkg::FILL_W-1:0]   fill_new;
    logic [9:0]                    spd10;
    logic [15:0]                   delta;
    logic [52:0]                   prod_lat, prod_lon;
    logic [30:0]                   qd_lat, qd_lon;
    logic [13:0]                   rem_lat, rem_lon;

    // Whole pipe moves together; it only halts when the last stage cannot push.
    assign adv        = !s3_valid_reg || push_ready;
    assign accept     = rec.valid && adv;
    assign rec.ready  = adv;
    assign push_valid = s3_valid_reg;
    assign push_entry = s3_entry_reg;

    // Classification and block bookkeeping
    always_comb
    begin
        fill_new = header_pending_reg ? plbp_pkg::FILL_W'(plbp_pkg::HDR_LEN)
                                      : byte_fill_reg + plbp_pkg::FILL_W'(plbp_pkg::REC_LEN);
        spd10 = 10'({rec.speed, 3'b000} + {2'b00, rec.speed, 1'b0});
        delta = rec.distance_m[15:0] - base_distance_reg[15:0];

        s1_entry_next       = '0;
        s1_entry_next.hdr   = header_pending_reg;
        s1_entry_next.close = fill_new > plbp_pkg::CLOSE_AT;
        if (header_pending_reg)
        begin
            s1_entry_next.bytes[0] = {3'b000, rec.day};
            s1_entry_next.bytes[1] = {rec.route_id, rec.month};
            s1_entry_next.bytes[2] = {7'b0000000, rec.direction};
            s1_entry_next.bytes[3] = rec.distance_m[23:16];
            s1_entry_next.bytes[4] = rec.distance_m[15:8];
            s1_entry_next.bytes[5] = rec.distance_m[7:0];
            s1_entry_next.bytes[6] = rec.altitude[15:8];
            s1_entry_next.bytes[7] = rec.altitude[7:0];
        end
        else
        begin
            s1_entry_next.bytes[0] = {rec.minute[2:0], rec.second[5:1]};
            s1_entry_next.bytes[1] = {rec.hour, rec.minute[5:3]};
            s1_entry_next.bytes[2] = {6'b000000, spd10[9:8]};
            s1_entry_next.bytes[3] = spd10[7:0];
            s1_entry_next.bytes[4] = delta[7:0];
            s1_entry_next.bytes[5] = delta[15:8];
        end

        header_pending_next = header_pending_reg;
        byte_fill_next      = byte_fill_reg;
        base_distance_next  = base_distance_reg;
        if (accept)
        begin
            if (header_pending_reg)
            begin
                base_distance_next = rec.distance_m;
            end
            if (s1_entry_next.close)
            begin
                header_pending_next = 1'b1;
                byte_fill_next      = '0;
            end
            else
            begin
                header_pending_next = 1'b0;
                byte_fill_next      = fill_new;
            end
        end
    end

    // Quotient by reciprocal, then remainder by back-multiplication
    always_comb
    begin
        prod_lat = 53'(s1_lat_reg[29:4]) * 53'(plbp_pkg::RECIP);
        prod_lon = 53'(s1_lon_reg[29:4]) * 53'(plbp_pkg::RECIP);
        qd_lat   = 31'(s2_qlat_reg) * 31'(plbp_pkg::GEO_DIV);
        qd_lon   = 31'(s2_qlon_reg) * 31'(plbp_pkg::GEO_DIV);
        rem_lat  = 14'(s2_lat_reg - qd_lat[29:0]);
        rem_lon  = 14'(s2_lon_reg - qd_lon[29:0]);

        s3_entry_next = s2_entry_reg;
        if (s2_entry_reg.hdr)
        begin
            s3_entry_next.bytes[8]  = s2_qlat_reg[15:8];
            s3_entry_next.bytes[9]  = s2_qlat_reg[7:0];
            s3_entry_next.bytes[10] = {2'b00, rem_lat[13:8]};
            s3_entry_next.bytes[11] = rem_lat[7:0];
            s3_entry_next.bytes[12] = s2_qlon_reg[15:8];
            s3_entry_next.bytes[13] = s2_qlon_reg[7:0];
            s3_entry_next.bytes[14] = {2'b00, rem_lon[13:8]};
            s3_entry_next.bytes[15] = rem_lon[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pending_reg <= 1'b1;
            byte_fill_reg      <= '0;
            base_distance_reg  <= '0;
            s1_valid_reg       <= 1'b0;
            s2_valid_reg       <= 1'b0;
            s3_valid_reg       <= 1'b0;
        end
        else
        begin
            header_pending_reg <= header_pending_next;
            byte_fill_reg      <= byte_fill_next;
            base_distance_reg  <= base_distance_next;
            if (adv)
            begin
                s1_valid_reg <= accept;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_entry_reg <= s1_entry_next;
            s1_lat_reg   <= rec.lat_code;
            s1_lon_reg   <= rec.lon_code;

            s2_entry_reg <= s1_entry_reg;
            s2_lat_reg   <= s1_lat_reg;
            s2_lon_reg   <= s1_lon_reg;
            s2_qlat_reg  <= prod_lat[plbp_pkg::RECIP_SHIFT +: 17];
            s2_qlon_reg  <= prod_lon[plbp_pkg::RECIP_SHIFT +: 17];

            s3_entry_reg <= s3_entry_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/plbp_queue.sv
// Short entry queue between the front end and the byte serialiser.
`timescale 1ns / 1ps
`default_nettype none

module plbp_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    input  wire plbp_pkg::entry_t  push_entry,
    output logic                   push_ready,
    output logic                   pop_valid,
    output plbp_pkg::entry_t       pop_entry,
    input  wire logic              pop_ready
);

    plbp_pkg::entry_t              mem [plbp_pkg::Q_DEPTH];
    logic [plbp_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [plbp_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [plbp_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                          push, pop;

    assign push_ready = count_reg != plbp_pkg::QCNT_W'(plbp_pkg::Q_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == plbp_pkg::QPTR_W'(plbp_pkg::Q_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == plbp_pkg::QPTR_W'(plbp_pkg::Q_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + plbp_pkg::QCNT_W'(push) - plbp_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/plbp_back.sv
// Back end: walks each entry out one byte per transaction through an output register.
`timescale 1ns / 1ps
`default_nettype none

module plbp_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pop_valid,
    input  wire plbp_pkg::entry_t  pop_entry,
    output logic                   pop_ready,
    plbp_out_if.source             log
);

    plbp_pkg::entry_t             cur_reg;
    logic                         cur_valid_reg, cur_valid_next;
    logic [plbp_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                         out_valid_reg, out_valid_next;
    plbp_pkg::byte_t              out_byte_reg;
    logic                         out_last_reg, out_end_reg;

    logic                         load, pop, cur_last;
    logic [plbp_pkg::IDX_W-1:0]   last_idx;

    assign last_idx  = cur_reg.hdr ? plbp_pkg::IDX_W'(plbp_pkg::HDR_LEN - 1)
                                   : plbp_pkg::IDX_W'(plbp_pkg::REC_LEN - 1);
    assign cur_last  = idx_reg == last_idx;
    assign load      = cur_valid_reg && (!out_valid_reg || log.ready);
    assign pop_ready = !cur_valid_reg || (load && cur_last);
    assign pop       = pop_valid && pop_ready;

    assign log.valid        = out_valid_reg;
    assign log.out_byte     = out_byte_reg;
    assign log.last_of_item = out_last_reg;
    assign log.block_end    = out_end_reg;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            idx_next = idx_reg + 1'b1;
            if (cur_last)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (log.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_entry;
        end
        if (load)
        begin
            out_byte_reg <= cur_reg.bytes[idx_reg];
            out_last_reg <= cur_last;
            out_end_reg  <= cur_last && cur_reg.close;
        end
    end

`ifndef SYNTH
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        log.valid && log.block_end |-> log.last_of_item)
        else $error("block_end without last_of_item");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> idx_reg <= last_idx)
        else $error("byte index past end of entry");

    a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> cur_valid_reg && idx_reg == '0)
        else $error("new entry not started at byte zero");
`endif

endmodule

`default_nettype wire

>>> sim/position_log_block_packer_test.sv
// Self-checking position log block packer test: directed and random records, byte checks.
`timescale 1ns / 1ps

module position_log_block_packer_test;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [3:0]  route_id;
        logic        direction;
        logic [23:0] distance_m;
        logic [15:0] altitude;
        logic [29:0] lat_code;
        logic [29:0] lon_code;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [6:0]  speed;
    } pos_rec_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last_of_item;
        logic       block_end;
    } log_byte_t;

    class log_block_checker;
        log_byte_t   due_bytes[$];
        bit          header_due = 1'b1;
        int          fill;
        logic [23:0] base_dist;
        int          errors;
        int          records;
        int          headers;
        int          bytes_seen;
        int          blocks_closed;

        // Work out the bytes a record turns into and queue them.
        function void note_record(pos_rec_t r);
            logic [7:0]  b [plbp_pkg::HDR_LEN];
            logic [15:0] lat_hi, lat_lo, lon_hi, lon_lo, delta;
            logic [9:0]  spd10;
            int          n;
            bit          closing;
            log_byte_t   e;
            records++;
            if (header_due) begin
                headers++;
                lat_hi = 16'(r.lat_code / 10000);
                lat_lo = 16'(r.lat_code % 10000);
                lon_hi = 16'(r.lon_code / 10000);
                lon_lo = 16'(r.lon_code % 10000);
                base_dist = r.distance_m;
                b[0]  = 8'(r.day);
                b[1]  = {r.route_id, r.month};
                b[2]  = 8'(r.direction);
                b[3]  = r.distance_m[23:16];
                b[4]  = r.distance_m[15:8];
                b[5]  = r.distance_m[7:0];
                b[6]  = r.altitude[15:8];
                b[7]  = r.altitude[7:0];
                b[8]  = lat_hi[15:8];
                b[9]  = lat_hi[7:0];
                b[10] = lat_lo[15:8];
                b[11] = lat_lo[7:0];
                b[12] = lon_hi[15:8];
                b[13] = lon_hi[7:0];
                b[14] = lon_lo[15:8];
                b[15] = lon_lo[7:0];
                n = plbp_pkg::HDR_LEN;
                fill = plbp_pkg::HDR_LEN;
                header_due = 1'b0;
            end
            else begin
                spd10 = 10'(r.speed * 10);
                delta = 16'(r.distance_m - base_dist);
                b[0] = {r.minute[2:0], r.second[5:1]};
                b[1] = {r.hour, r.minute[5:3]};
                b[2] = {6'b0, spd10[9:8]};
                b[3] = spd10[7:0];
                b[4] = delta[7:0];
                b[5] = delta[15:8];
                n = plbp_pkg::REC_LEN;
                fill += plbp_pkg::REC_LEN;
            end
            // closes as soon as a short record would no longer fit
            closing = (fill >= plbp_pkg::BLOCK_BYTES) ||
                      (plbp_pkg::BLOCK_BYTES - fill < plbp_pkg::REC_LEN);
            if (closing) begin
                fill = 0;
                header_due = 1'b1;
            end
            for (int i = 0; i < n; i++) begin
                e.value        = b[i];
                e.last_of_item = (i == n - 1);
                e.block_end    = (i == n - 1) && closing;
                due_bytes.push_back(e);
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] MISMATCH byte %0d: %s", $realtime, bytes_seen, msg);
        endtask

        task check_byte(logic [7:0] value, logic last_of_item, logic block_end);
            log_byte_t e;
            bytes_seen++;
            if (block_end === 1'b1)
                blocks_closed++;
            if (due_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h", value));
            end
            else begin
                e = due_bytes[0];
                due_bytes.delete(0);
                if (value !== e.value)
                    report_mismatch($sformatf("out_byte %02h, want %02h", value, e.value));
                if (last_of_item !== e.last_of_item)
                    report_mismatch($sformatf("last_of_item %b, want %b",
                                              last_of_item, e.last_of_item));
                if (block_end !== e.block_end)
                    report_mismatch($sformatf("block_end %b, want %b",
                                              block_end, e.block_end));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   idle_on;
    logic [23:0] next_dist;

    log_block_checker sb;

    plbp_in_if  rec_ch ();
    plbp_out_if log_ch ();

    position_log_block_packer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rec   (rec_ch),
        .log   (log_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("position_log_block_packer_test: done, errors");
        $finish;
    end

    // Present one record and hold it until its transaction completes.
    task send_record(pos_rec_t r);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            rec_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rec_ch.valid      <= 1'b1;
        rec_ch.day        <= r.day;
        rec_ch.month      <= r.month;
        rec_ch.route_id   <= r.route_id;
        rec_ch.direction  <= r.direction;
        rec_ch.distance_m <= r.distance_m;
        rec_ch.altitude   <= r.altitude;
        rec_ch.lat_code   <= r.lat_code;
        rec_ch.lon_code   <= r.lon_code;
        rec_ch.hour       <= r.hour;
        rec_ch.minute     <= r.minute;
        rec_ch.second     <= r.second;
        rec_ch.speed      <= r.speed;
        do
            @(posedge clk);
        while (rec_ch.ready !== 1'b1);
        sb.note_record(r);
    endtask

    function pos_rec_t random_record();
        pos_rec_t r;
        if ($urandom_range(0, 5) == 0)
        begin
            // any value the field widths allow
            r = pos_rec_t'(138'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        end
        else
        begin
            r.day       = 5'($urandom_range(1, 31));
            r.month     = 4'($urandom_range(1, 12));
            r.route_id  = 4'($urandom);
            r.direction = 1'($urandom);
            if ($urandom_range(0, 9) == 0)
                next_dist = 24'($urandom);
            else
                next_dist = next_dist + 24'($urandom_range(0, 2000)) - 24'd500;
            r.distance_m = next_dist;
            r.altitude   = 16'($urandom);
            r.lat_code   = 30'($urandom_range(0, 655359999));
            r.lon_code   = 30'($urandom_range(0, 655359999));
            r.hour       = 5'($urandom_range(0, 23));
            r.minute     = 6'($urandom_range(0, 59));
            r.second     = 6'($urandom_range(0, 59));
            r.speed      = 7'($urandom_range(0, 102));
        end
        return r;
    endfunction

    // Byte sink with random back-pressure.
    initial
    begin
        int stall;
        log_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 5) : 0;
            if (stall > 0)
            begin
                log_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            log_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (log_ch.valid !== 1'b1);
            sb.check_byte(log_ch.out_byte, log_ch.last_of_item, log_ch.block_end);
        end
    end

    initial
    begin
        pos_rec_t r;
        sb = new;
        idle_on   = 1'b0;
        next_dist = 24'd0;
        rst_n             <= 1'b0;
        rec_ch.valid      <= 1'b0;
        rec_ch.day        <= '0;
        rec_ch.month      <= '0;
        rec_ch.route_id   <= '0;
        rec_ch.direction  <= 1'b0;
        rec_ch.distance_m <= '0;
        rec_ch.altitude   <= '0;
        rec_ch.lat_code   <= '0;
        rec_ch.lon_code   <= '0;
        rec_ch.hour       <= '0;
        rec_ch.minute     <= '0;
        rec_ch.second     <= '0;
        rec_ch.speed      <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // header, all ones but lon_code; only the lat quotient overflows 16 bits
        r = '1;
        r.lon_code = 30'd655359999;
        send_record(r);
        // all-zero short record: delta wraps to 1
        r = '0;
        send_record(r);
        // widest time and speed, delta of zero
        r = '1;
        send_record(r);
        r = '0;
        r.distance_m = 24'hFFFFFE;
        r.speed = 7'd102;
        send_record(r);
        r.speed = 7'd103;
        send_record(r);
        r.speed = 7'd1;
        r.distance_m = 24'hFFFFFF + 24'd32767;
        send_record(r);
        r.distance_m = 24'hFFFFFF + 24'd32768;
        send_record(r);
        r.distance_m = 24'hFFFFFF + 24'd65536;
        send_record(r);
        r.hour = 5'd23;
        r.minute = 6'd59;
        r.second = 6'd58;
        r.distance_m = 24'h00FFFF;
        send_record(r);

        idle_on = 1'b1;
        repeat (120) send_record(random_record());
        idle_on = 1'b0;
        repeat (110) send_record(random_record());
        idle_on = 1'b1;
        repeat (120) send_record(random_record());
        rec_ch.valid <= 1'b0;

        while (sb.due_bytes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d records (%0d headers), %0d bytes checked, %0d blocks closed",
                 sb.records, sb.headers, sb.bytes_seen, sb.blocks_closed);
        if (sb.errors == 0)
            $display("position_log_block_packer_test: done, clean");
        else
            $display("position_log_block_packer_test: done, errors");
        $finish;
    end

endmodule

>>> position_log_block_packer.f
rtl/core/plbp_pkg.sv
rtl/core/plbp_if.sv
rtl/core/plbp_front.sv
rtl/core/plbp_queue.sv
rtl/core/plbp_back.sv
rtl/core/position_log_block_packer.sv
sim/position_log_block_packer_test.sv
